// ===== src/csvr_pkg.sv =====
// ----------------------------------------------------------------------------
// csvr_pkg: shared definitions for the character row generator
// Sizes of the screen and pattern stores, field widths and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csvr_pkg;

	// store sizes
	localparam int SCREEN_CELLS  = 1024;
	localparam int PATTERN_BYTES = 1024;

	// item field widths
	localparam int FUNC_W = 2;
	localparam int ADDR_W = 10;
	localparam int DATA_W = 8;
	localparam int ROW_W  = 4;
	localparam int PIX_W  = 8;

	// derived address widths
	localparam int SCR_AW = $clog2(SCREEN_CELLS);
	localparam int PAT_AW = $clog2(PATTERN_BYTES);
	localparam int EXT_W  = (SCR_AW > ADDR_W) ? SCR_AW : ADDR_W;

	// stream widths
	localparam int S_DATA_W = 24;
	localparam int S_USER_W = FUNC_W;
	localparam int M_DATA_W = 16;

	// character cell geometry and codes
	localparam logic [ROW_W-1:0]  CELL_ROWS  = 4'd12;
	localparam logic [DATA_W-1:0] SPACE_CODE = 8'h20;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WR_SCREEN  = 2'd0,
		FUNC_WR_PATTERN = 2'd1,
		FUNC_FETCH      = 2'd2
	} func_t;

endpackage

`default_nettype wire

// ===== src/csvr_ram.sv =====
// ----------------------------------------------------------------------------
// csvr_ram: generic single-clock RAM
// One write port and one read port; read data is registered and returns
// the old contents on a same-address write.
// ----------------------------------------------------------------------------
`default_nettype none

module csvr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/character_semigraphics_video_row.sv =====
// ----------------------------------------------------------------------------
// character_semigraphics_video_row: text-mode pixel row generator
// Screen store of character codes, pattern store of glyph rows, and 2x3
// block graphics for codes with bit 7 set. Items write a screen byte,
// write a pattern byte or fetch the 8-pixel row of one cell.
// ----------------------------------------------------------------------------
// Throughput is one item per clock while the output is not stalled; every item
// yields one result (screen read in stage 1, pattern read in stage 2,
// output register in stage 3). Back-pressure on the output stalls all stages
// without loss. After reset the block first sweeps the screen store to the
// space code, one cell per clock, so s_tready stays low until all
// SCREEN_CELLS (1024) cells are cleared. Screen writes compare against the
// stored byte and report whether it changed; a fetch right behind a write
// to the same cell sees the new byte. Unwritten pattern bytes read as unknown.
// ----------------------------------------------------------------------------
`default_nettype none

module character_semigraphics_video_row (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input items
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [csvr_pkg::S_DATA_W-1:0] s_tdata,  // addr[9:0], data[17:10], row[21:18]
	input  wire logic [csvr_pkg::S_USER_W-1:0] s_tuser,  // func[1:0]
	// result items
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [csvr_pkg::M_DATA_W-1:0] m_tdata   // pixels[7:0], changed[8]
);

	typedef enum logic [1:0] {
		PIX_ZERO,
		PIX_GLYPH,
		PIX_BLOCK
	} pix_kind_t;

	localparam int AW  = csvr_pkg::ADDR_W;
	localparam int DW  = csvr_pkg::DATA_W;
	localparam int RW  = csvr_pkg::ROW_W;
	localparam int SAW = csvr_pkg::SCR_AW;
	localparam int PAW = csvr_pkg::PAT_AW;
	localparam int XW  = csvr_pkg::EXT_W;
	localparam logic [SAW-1:0] LAST_CELL = SAW'(csvr_pkg::SCREEN_CELLS - 1);

	// input field split
	logic [AW-1:0]  in_addr;
	logic [DW-1:0]  in_data;
	logic [RW-1:0]  in_row;
	logic [XW-1:0]  in_ext;
	logic [SAW-1:0] in_idx;
	logic           in_inr;

	assign in_addr = s_tdata[AW-1:0];
	assign in_data = s_tdata[AW+DW-1:AW];
	assign in_row  = s_tdata[AW+DW+RW-1:AW+DW];
	assign in_ext  = XW'(in_addr);
	assign in_idx  = in_ext[SAW-1:0];
	assign in_inr  = ((XW+1)'(in_ext) < (XW+1)'(csvr_pkg::SCREEN_CELLS));

	// clearing pass state
	logic           clr_busy_q;
	logic [SAW-1:0] clr_idx_q;

	// stage registers
	logic                  v_s1, v_s2, v_s3;
	csvr_pkg::func_t       func_s1;
	logic [AW-1:0]         addr_s1;
	logic [SAW-1:0]        idx_s1;
	logic                  inr_s1;
	logic [DW-1:0]         data_s1;
	logic [RW-1:0]         row_s1;
	logic                  fwd_s1;
	logic [DW-1:0]         fwd_data_s1;
	pix_kind_t             kind_s2;
	logic [csvr_pkg::PIX_W-1:0] blk_s2;
	logic                  chg_s2;
	logic [csvr_pkg::PIX_W-1:0] pix_s3;
	logic                  chg_s3;

	// stage enables
	logic en1, en2, en3;
	assign en3 = !v_s3 || m_tready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1 && !clr_busy_q;

	logic accept;
	assign accept = s_tvalid && s_tready;

	// screen write commits when the write leaves stage 1
	logic scr_commit;
	assign scr_commit = v_s1 && en2 && (func_s1 == csvr_pkg::FUNC_WR_SCREEN) && inr_s1;

	// screen store
	logic           scr_we;
	logic [SAW-1:0] scr_waddr;
	logic [DW-1:0]  scr_wdata;
	logic [DW-1:0]  scr_rdata;

	assign scr_we    = clr_busy_q || scr_commit;
	assign scr_waddr = clr_busy_q ? clr_idx_q : idx_s1;
	assign scr_wdata = clr_busy_q ? csvr_pkg::SPACE_CODE : data_s1;

	csvr_ram #(
		.WIDTH (DW),
		.DEPTH (csvr_pkg::SCREEN_CELLS)
	) u_screen (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.re    (en1),
		.raddr (in_idx),
		.rdata (scr_rdata)
	);

	// stage 1 decode: current code, change flag, pixel kind
	logic [DW-1:0]  code_s1;
	logic [1:0]     band_s1;
	logic           chg_d;
	pix_kind_t      kind_d;
	logic [csvr_pkg::PIX_W-1:0] blk_d;
	logic [PAW-1:0] pat_raddr;
	logic           pat_we;

	assign code_s1 = fwd_s1 ? fwd_data_s1 : scr_rdata;
	assign band_s1 = row_s1[3:2];
	assign chg_d   = (func_s1 == csvr_pkg::FUNC_WR_SCREEN) && inr_s1 && (code_s1 != data_s1);
	assign blk_d   = {{4{code_s1[{band_s1, 1'b0}]}}, {4{code_s1[{band_s1, 1'b1}]}}};
	assign pat_raddr = PAW'({code_s1[6:0], row_s1[2:0]});
	assign pat_we  = v_s1 && en2 && (func_s1 == csvr_pkg::FUNC_WR_PATTERN);

	always_comb begin
		kind_d = PIX_ZERO;
		if (func_s1 == csvr_pkg::FUNC_FETCH && inr_s1 && row_s1 < csvr_pkg::CELL_ROWS) begin
			if (code_s1[7]) begin
				kind_d = PIX_BLOCK;
			end else if (!row_s1[3]) begin
				kind_d = PIX_GLYPH;
			end
		end
	end

	// pattern store: reads and writes both issue as the item leaves stage 1
	logic [DW-1:0] pat_rdata;

	csvr_ram #(
		.WIDTH (DW),
		.DEPTH (csvr_pkg::PATTERN_BYTES)
	) u_pattern (
		.clk   (clk),
		.we    (pat_we),
		.waddr (addr_s1[PAW-1:0]),
		.wdata (data_s1),
		.re    (en2),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST_CELL) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1 payload; forward a screen write that commits on the same edge
	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1     <= csvr_pkg::func_t'(s_tuser);
			addr_s1     <= in_addr;
			idx_s1      <= in_idx;
			inr_s1      <= in_inr;
			data_s1     <= in_data;
			row_s1      <= in_row;
			fwd_s1      <= scr_commit && (idx_s1 == in_idx);
			fwd_data_s1 <= data_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2 <= kind_d;
			blk_s2  <= blk_d;
			chg_s2  <= chg_d;
		end
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (en3) begin
			case (kind_s2)
				PIX_GLYPH: pix_s3 <= pat_rdata;
				PIX_BLOCK: pix_s3 <= blk_s2;
				default:   pix_s3 <= '0;
			endcase
			chg_s3 <= chg_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {{(csvr_pkg::M_DATA_W - csvr_pkg::PIX_W - 1){1'b0}}, chg_s3, pix_s3};

	// no item is taken while the screen store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("item accepted during clearing pass");

	// a changed flag only comes from a write, which carries blank pixels
	a_changed_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[csvr_pkg::PIX_W]) |-> (m_tdata[csvr_pkg::PIX_W-1:0] == '0))
		else $error("changed result with nonzero pixels");

	// the clearing pass ends only after the last cell
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> ($past(clr_idx_q) == LAST_CELL))
		else $error("clearing pass ended early");

	// a screen commit, which may be forwarded, comes only from a valid stage-1 item outside the clearing pass
	a_fwd_only_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		(en1 && scr_commit) |-> (v_s1 && !clr_busy_q))
		else $error("screen commit without a valid write item");

endmodule

`default_nettype wire
